/* rtl/itp_pkg.sv */
package itp_pkg;

	// counter geometry
	localparam int NUM_REGS = 32;
	localparam int REG_AW   = $clog2(NUM_REGS);
	localparam int CNT_W    = 32;
	localparam int VAL_W    = 32;
	localparam int IDX_W    = 7;
	localparam int NUM_SCAL = 10;
	localparam int SCAL_AW  = $clog2(NUM_SCAL);

	localparam logic [CNT_W-1:0] CNT_TOP = {CNT_W{1'b1}};

	// item codes on the opcode field
	localparam logic ITEM_TRACE = 1'b0;
	localparam logic ITEM_READ  = 1'b1;

	// counter index map
	localparam int CNT_INSTS = 0;
	localparam int CNT_RTYPE = 1;
	localparam int CNT_ITYPE = 2;
	localparam int CNT_JTYPE = 3;
	localparam int CNT_FWD   = 4;
	localparam int CNT_BKW   = 5;
	localparam int CNT_NOT   = 6;
	localparam int CNT_LOAD  = 7;
	localparam int CNT_STORE = 8;
	localparam int CNT_ARITH = 9;

	localparam logic [IDX_W-1:0] REG_RD_BASE = IDX_W'(NUM_SCAL);
	localparam logic [IDX_W-1:0] REG_WR_BASE = IDX_W'(NUM_SCAL + NUM_REGS);
	localparam logic [IDX_W-1:0] IDX_LIMIT   = IDX_W'(NUM_SCAL + 2 * NUM_REGS);

	// major opcodes
	localparam logic [5:0] IOP_RTYPE = 6'd0;
	localparam logic [5:0] IOP_J     = 6'd2;
	localparam logic [5:0] IOP_JAL   = 6'd3;
	localparam logic [5:0] IOP_BEQ   = 6'd4;
	localparam logic [5:0] IOP_BNE   = 6'd5;
	localparam logic [5:0] IOP_ADDI  = 6'd8;
	localparam logic [5:0] IOP_ADDIU = 6'd9;
	localparam logic [5:0] IOP_SLTI  = 6'd10;
	localparam logic [5:0] IOP_SLTIU = 6'd11;
	localparam logic [5:0] IOP_ANDI  = 6'd12;
	localparam logic [5:0] IOP_ORI   = 6'd13;
	localparam logic [5:0] IOP_LUI   = 6'd15;
	localparam logic [5:0] IOP_LW    = 6'd35;
	localparam logic [5:0] IOP_LBU   = 6'd36;
	localparam logic [5:0] IOP_LHU   = 6'd37;
	localparam logic [5:0] IOP_SB    = 6'd40;
	localparam logic [5:0] IOP_SH    = 6'd41;
	localparam logic [5:0] IOP_SW    = 6'd43;

	// register-format funct codes
	localparam logic [5:0] FN_SLL     = 6'd0;
	localparam logic [5:0] FN_SRL     = 6'd2;
	localparam logic [5:0] FN_SRA     = 6'd3;
	localparam logic [5:0] FN_JR      = 6'd8;
	localparam logic [5:0] FN_SYSCALL = 6'd12;
	localparam logic [5:0] FN_ADD     = 6'd32;
	localparam logic [5:0] FN_ADDU    = 6'd33;
	localparam logic [5:0] FN_SUB     = 6'd34;
	localparam logic [5:0] FN_SUBU    = 6'd35;
	localparam logic [5:0] FN_AND     = 6'd36;
	localparam logic [5:0] FN_OR      = 6'd37;
	localparam logic [5:0] FN_XOR     = 6'd38;
	localparam logic [5:0] FN_NOR     = 6'd39;
	localparam logic [5:0] FN_SLT     = 6'd42;
	localparam logic [5:0] FN_SLTU    = 6'd43;

	// decoded word carried from accept to the update stage
	typedef struct packed {
		logic                   is_read;
		logic [IDX_W-1:0]       idx;
		logic [NUM_SCAL-1:0]    cnt_inc;
		logic                   rs_inc;
		logic                   rt_inc;
		logic                   wr_inc;
	} dec_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == CNT_TOP) ? v : v + CNT_W'(1);
	endfunction

	// sum of two saturating partial counts, saturated again
	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add = s[CNT_W] ? CNT_TOP : s[CNT_W-1:0];
	endfunction

endpackage

/* rtl/itp_ram.sv */
module itp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/itp_decode.sv */
module itp_decode (
	input  logic                        opcode,
	input  logic [31:0]                 pc_address,
	input  logic [31:0]                 instr_word,
	input  logic [31:0]                 following_address,
	input  logic                        final_record,
	input  logic [itp_pkg::IDX_W-1:0]   counter_index,
	output itp_pkg::dec_t               dec,
	output logic [itp_pkg::REG_AW-1:0]  rs_addr,
	output logic [itp_pkg::REG_AW-1:0]  rt_addr,
	output logic [itp_pkg::REG_AW-1:0]  wr_addr
);

	logic [5:0]                  iop;
	logic [5:0]                  fn;
	logic [itp_pkg::REG_AW-1:0]  rs;
	logic [itp_pkg::REG_AW-1:0]  rt;
	logic [itp_pkg::REG_AW-1:0]  rd;
	logic [itp_pkg::IDX_W-1:0]   rd_off;
	logic [itp_pkg::IDX_W-1:0]   wr_off;
	logic [31:0]                 seq;
	logic                        back;
	logic                        br_not;
	logic                        br_fwd;
	logic                        jp_fwd;

	assign iop = instr_word[31:26];
	assign fn  = instr_word[5:0];
	assign rs  = instr_word[25:21];
	assign rt  = instr_word[20:16];
	assign rd  = instr_word[15:11];

	// direction compares, all unsigned on 32-bit addresses (pc + 4 wraps)
	assign seq    = pc_address + 32'd4;
	assign back   = following_address < pc_address;
	assign br_not = !back && (following_address == seq);
	assign br_fwd = !back && (following_address > seq);
	assign jp_fwd = following_address > pc_address;

	// bank addresses: register fields for a trace word, counter offset for a read
	assign rd_off  = counter_index - itp_pkg::REG_RD_BASE;
	assign wr_off  = counter_index - itp_pkg::REG_WR_BASE;
	assign rs_addr = dec.is_read ? rd_off[itp_pkg::REG_AW-1:0] : rs;
	assign rt_addr = dec.is_read ? rd_off[itp_pkg::REG_AW-1:0] : rt;
	assign wr_addr = dec.is_read ? wr_off[itp_pkg::REG_AW-1:0] :
		((iop == itp_pkg::IOP_RTYPE) ? rd : rt);

	// classify the word into counter increments
	always_comb begin
		dec         = '0;
		dec.is_read = (opcode == itp_pkg::ITEM_READ);
		dec.idx     = counter_index;
		if (!dec.is_read) begin
			dec.cnt_inc[itp_pkg::CNT_INSTS] = 1'b1;
			if (iop == itp_pkg::IOP_RTYPE) begin
				dec.cnt_inc[itp_pkg::CNT_RTYPE] = 1'b1;
				if (fn inside {itp_pkg::FN_ADD, itp_pkg::FN_ADDU, itp_pkg::FN_SUB,
					itp_pkg::FN_SUBU, itp_pkg::FN_AND, itp_pkg::FN_OR, itp_pkg::FN_XOR,
					itp_pkg::FN_NOR, itp_pkg::FN_SLT, itp_pkg::FN_SLTU}) begin
					dec.wr_inc = 1'b1;
					dec.rt_inc = 1'b1;
					dec.rs_inc = 1'b1;
					dec.cnt_inc[itp_pkg::CNT_ARITH] = 1'b1;
				end else if (fn inside {itp_pkg::FN_SLL, itp_pkg::FN_SRL,
					itp_pkg::FN_SRA}) begin
					dec.wr_inc = 1'b1;
					dec.rt_inc = 1'b1;
					dec.cnt_inc[itp_pkg::CNT_ARITH] = 1'b1;
				end else if (fn == itp_pkg::FN_SYSCALL) begin
					dec.cnt_inc[itp_pkg::CNT_ARITH] = 1'b1;
				end else if (fn == itp_pkg::FN_JR && !final_record) begin
					dec.cnt_inc[itp_pkg::CNT_BKW] = back;
					dec.cnt_inc[itp_pkg::CNT_NOT] = br_not;
					dec.cnt_inc[itp_pkg::CNT_FWD] = br_fwd;
					dec.rs_inc = 1'b1;
				end
			end else if (iop == itp_pkg::IOP_J || iop == itp_pkg::IOP_JAL) begin
				dec.cnt_inc[itp_pkg::CNT_JTYPE] = 1'b1;
				if (!final_record) begin
					dec.cnt_inc[itp_pkg::CNT_BKW] = back;
					dec.cnt_inc[itp_pkg::CNT_FWD] = !back && jp_fwd;
				end
			end else begin
				dec.cnt_inc[itp_pkg::CNT_ITYPE] = 1'b1;
				if (iop inside {itp_pkg::IOP_ADDI, itp_pkg::IOP_ADDIU, itp_pkg::IOP_SLTI,
					itp_pkg::IOP_SLTIU, itp_pkg::IOP_ANDI, itp_pkg::IOP_ORI}) begin
					dec.wr_inc = 1'b1;
					dec.rs_inc = 1'b1;
					dec.cnt_inc[itp_pkg::CNT_ARITH] = 1'b1;
				end else if (iop == itp_pkg::IOP_LUI) begin
					dec.wr_inc = 1'b1;
					dec.cnt_inc[itp_pkg::CNT_ARITH] = 1'b1;
				end else if (iop inside {itp_pkg::IOP_LW, itp_pkg::IOP_LBU,
					itp_pkg::IOP_LHU}) begin
					dec.rs_inc = 1'b1;
					dec.wr_inc = 1'b1;
					dec.cnt_inc[itp_pkg::CNT_LOAD] = 1'b1;
				end else if (iop inside {itp_pkg::IOP_SB, itp_pkg::IOP_SH,
					itp_pkg::IOP_SW}) begin
					dec.rt_inc = 1'b1;
					dec.rs_inc = 1'b1;
					dec.cnt_inc[itp_pkg::CNT_STORE] = 1'b1;
				end else if ((iop == itp_pkg::IOP_BEQ || iop == itp_pkg::IOP_BNE)
					&& !final_record) begin
					dec.cnt_inc[itp_pkg::CNT_BKW] = back;
					dec.cnt_inc[itp_pkg::CNT_NOT] = br_not;
					dec.cnt_inc[itp_pkg::CNT_FWD] = br_fwd;
					dec.rt_inc = 1'b1;
					dec.rs_inc = 1'b1;
				end
			end
		end
	end

endmodule

/* rtl/itp_bank.sv */
module itp_bank (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [itp_pkg::REG_AW-1:0]  rd_addr,
	input  logic                        upd,
	output logic [itp_pkg::CNT_W-1:0]   value
);

	logic [itp_pkg::REG_AW-1:0]   addr_s1;
	logic [itp_pkg::CNT_W-1:0]    ram_q;
	logic [itp_pkg::NUM_REGS-1:0] vld_q;
	logic                         fwd_vld_q;
	logic [itp_pkg::REG_AW-1:0]   fwd_addr_q;
	logic [itp_pkg::CNT_W-1:0]    fwd_data_q;
	logic [itp_pkg::CNT_W-1:0]    new_val;

	itp_ram #(
		.WIDTH(itp_pkg::CNT_W),
		.DEPTH(itp_pkg::NUM_REGS)
	) u_ram (
		.clk   (clk),
		.we    (upd),
		.waddr (addr_s1),
		.wdata (new_val),
		.raddr (rd_addr),
		.rdata (ram_q)
	);

	// address of the entry whose data arrives this cycle
	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
	end

	// current value: last write wins over ram data, unwritten entries read zero
	always_comb begin
		if (fwd_vld_q && fwd_addr_q == addr_s1) begin
			value = fwd_data_q;
		end else if (vld_q[addr_s1]) begin
			value = ram_q;
		end else begin
			value = '0;
		end
	end

	assign new_val = itp_pkg::sat_inc(value);

	// entry valid bits and write-back forwarding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			fwd_vld_q <= 1'b0;
		end else begin
			fwd_vld_q <= upd;
			if (upd) begin
				vld_q[addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= addr_s1;
		fwd_data_q <= new_val;
	end

endmodule

/* rtl/instruction_trace_profiler.sv */
// Instruction trace profiler.
// Input channel (in_valid / in_ready): one word per retired instruction
// (opcode = trace) or a counter query (opcode = read, counter_index selects).
// Output channel (out_valid / out_ready): one word per query, carrying
// counter_value and echoed_index; trace words produce no output.
// Throughput: one input word per cycle, trace or query, in any mix, while in_ready is high.
// A query accepted on the input passes through the update stage and into the
// output head register (via the skid if the head is stalled) before out_valid
// rises; it sees every trace word accepted before it.
// Per-register read and write counts live in three 32-entry RAMs (rs reads,
// rt reads, writes) updated read-modify-write with a write-back forwarding register;
// read count = saturating sum of the rs and rt banks. Scalar totals are flops.
// Reset clears all counters at once (per-entry valid bits on the RAMs), so
// the block takes words in the first cycle after reset.
// A two-deep output buffer absorbs results while out_ready is low; in_ready
// drops only when that buffer and the query in flight could overflow it.
module instruction_trace_profiler (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        opcode,
	input  logic [31:0]                 pc_address,
	input  logic [31:0]                 instr_word,
	input  logic [31:0]                 following_address,
	input  logic                        final_record,
	input  logic [itp_pkg::IDX_W-1:0]   counter_index,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [itp_pkg::VAL_W-1:0]   counter_value,
	output logic [itp_pkg::IDX_W-1:0]   echoed_index
);

	itp_pkg::dec_t               dec;
	itp_pkg::dec_t               dec_s1;
	logic                        valid_s1;
	logic [itp_pkg::REG_AW-1:0]  rs_addr;
	logic [itp_pkg::REG_AW-1:0]  rt_addr;
	logic [itp_pkg::REG_AW-1:0]  wr_addr;
	logic [itp_pkg::CNT_W-1:0]   rs_val;
	logic [itp_pkg::CNT_W-1:0]   rt_val;
	logic [itp_pkg::CNT_W-1:0]   wr_val;
	logic [itp_pkg::CNT_W-1:0]   cnt_q [itp_pkg::NUM_SCAL];
	logic                        accept;
	logic                        push;
	logic                        pop;
	logic [1:0]                  occ_next;
	logic [itp_pkg::CNT_W-1:0]   sel_val;
	logic [itp_pkg::VAL_W-1:0]   push_val;
	logic                        out_vld_q;
	logic [itp_pkg::VAL_W-1:0]   out_val_q;
	logic [itp_pkg::IDX_W-1:0]   out_idx_q;
	logic                        skid_vld_q;
	logic [itp_pkg::VAL_W-1:0]   skid_val_q;
	logic [itp_pkg::IDX_W-1:0]   skid_idx_q;

	itp_decode u_decode (
		.opcode            (opcode),
		.pc_address        (pc_address),
		.instr_word        (instr_word),
		.following_address (following_address),
		.final_record      (final_record),
		.counter_index     (counter_index),
		.dec               (dec),
		.rs_addr           (rs_addr),
		.rt_addr           (rt_addr),
		.wr_addr           (wr_addr)
	);

	// register read counts, split by operand slot
	itp_bank u_rs_bank (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rs_addr),
		.upd     (valid_s1 && dec_s1.rs_inc),
		.value   (rs_val)
	);

	itp_bank u_rt_bank (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rt_addr),
		.upd     (valid_s1 && dec_s1.rt_inc),
		.value   (rt_val)
	);

	// register write counts
	itp_bank u_wr_bank (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (wr_addr),
		.upd     (valid_s1 && dec_s1.wr_inc),
		.value   (wr_val)
	);

	// input handshake and credit against the output buffer
	assign accept   = in_valid && in_ready;
	assign push     = valid_s1 && dec_s1.is_read;
	assign pop      = out_vld_q && out_ready;
	assign occ_next = 2'(out_vld_q) + 2'(skid_vld_q) + 2'(push) - 2'(pop);
	assign in_ready = (occ_next < 2'd2);

	// update stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		dec_s1 <= dec;
	end

	// scalar totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < itp_pkg::NUM_SCAL; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < itp_pkg::NUM_SCAL; i++) begin
				if (valid_s1 && dec_s1.cnt_inc[i]) begin
					cnt_q[i] <= itp_pkg::sat_inc(cnt_q[i]);
				end
			end
		end
	end

	// counter select for a query
	always_comb begin
		if (dec_s1.idx < itp_pkg::REG_RD_BASE) begin
			sel_val = cnt_q[dec_s1.idx[itp_pkg::SCAL_AW-1:0]];
		end else if (dec_s1.idx < itp_pkg::REG_WR_BASE) begin
			sel_val = itp_pkg::sat_add(rs_val, rt_val);
		end else if (dec_s1.idx < itp_pkg::IDX_LIMIT) begin
			sel_val = wr_val;
		end else begin
			sel_val = '0;
		end
	end

	assign push_val = itp_pkg::VAL_W'(sel_val);

	// two-deep output buffer: head register plus skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (pop || !out_vld_q) begin
				if (skid_vld_q) begin
					out_vld_q  <= 1'b1;
					skid_vld_q <= push;
				end else begin
					out_vld_q <= push;
				end
			end else if (push) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !out_vld_q) begin
			if (skid_vld_q) begin
				out_val_q <= skid_val_q;
				out_idx_q <= skid_idx_q;
				if (push) begin
					skid_val_q <= push_val;
					skid_idx_q <= dec_s1.idx;
				end
			end else begin
				out_val_q <= push_val;
				out_idx_q <= dec_s1.idx;
			end
		end else if (push) begin
			skid_val_q <= push_val;
			skid_idx_q <= dec_s1.idx;
		end
	end

	assign out_valid     = out_vld_q;
	assign counter_value = out_val_q;
	assign echoed_index  = out_idx_q;

	// skid holds a word only behind a full head
	a_skid_behind_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid word without head word");

	// a full buffer that is not draining refuses new words
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && skid_vld_q && !out_ready) |-> !in_ready)
		else $error("input accepted with output buffer full");

	// an accepted query reaches the update stage next cycle
	a_query_flows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == itp_pkg::ITEM_READ) |=> push)
		else $error("query lost before update stage");

	// a trace word never produces a result
	a_trace_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == itp_pkg::ITEM_TRACE) |=> !push)
		else $error("trace word produced a result");

	// a stalled head word holds its value
	a_head_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_ready) |=> (out_vld_q && $stable(out_val_q)
		&& $stable(out_idx_q)))
		else $error("head word changed while stalled");

endmodule
